### rtl/lgrs_pkg.sv
// Shared types and constants for the Life generation row stream core.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package lgrs_pkg;

  localparam int unsigned RowW        = 64;
  localparam int unsigned ColW        = $clog2(RowW);
  localparam int unsigned IdxW        = 16;
  localparam int unsigned CfgW        = 7;
  localparam int unsigned DefMaxWidth = 64;
  localparam int unsigned DefMaxRows  = 65536;

  localparam logic [CfgW-1:0] RowWidthReset = CfgW'(64);

  // Number of results a transaction produces
  localparam logic [1:0] NumNone  = 2'd0;
  localparam logic [1:0] NumOne   = 2'd1;
  localparam logic [1:0] NumTwo   = 2'd2;
  localparam logic [1:0] NumThree = 2'd3;

  typedef struct packed {
    logic [RowW-1:0] row_cells;
    logic            is_last_row;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0] row_index;
    logic [RowW-1:0] next_row_cells;
    logic            last_of_generation;
  } out_item_t;

  // A 3x3 neighbourhood, one field per column: bit 2 above, bit 1 centre, bit 0 below
  typedef struct packed {
    logic [2:0] west;
    logic [2:0] mid;
    logic [2:0] east;
  } nbhd_t;

endpackage

`default_nettype wire

### rtl/lgrs_lane.sv
// One cell of the B3/S23 rule: counts eight neighbours and decides the next state.
// Depends on lgrs_pkg for the neighbourhood type.
`timescale 1ns / 1ps
`default_nettype none

module lgrs_lane (
  input  lgrs_pkg::nbhd_t nbhd_i,
  output logic            next_o
);
  import lgrs_pkg::*;

  logic [3:0] count;
  logic       alive;

  assign alive = nbhd_i.mid[1];

  assign count = 4'(nbhd_i.west[2]) + 4'(nbhd_i.west[1]) + 4'(nbhd_i.west[0])
               + 4'(nbhd_i.mid[2])                       + 4'(nbhd_i.mid[0])
               + 4'(nbhd_i.east[2]) + 4'(nbhd_i.east[1]) + 4'(nbhd_i.east[0]);

  assign next_o = (count == 4'd3) || (alive && (count == 4'd2));

endmodule

`default_nettype wire

### rtl/lgrs_row_eval.sv
// Row evaluator: one lane per column with horizontal wrap, merged into a masked row.
// Depends on lgrs_pkg and lgrs_lane.
`timescale 1ns / 1ps
`default_nettype none

module lgrs_row_eval #(
  parameter int unsigned MaxWidth = lgrs_pkg::DefMaxWidth
) (
  input  logic [lgrs_pkg::RowW-1:0] above_i,
  input  logic [lgrs_pkg::RowW-1:0] centre_i,
  input  logic [lgrs_pkg::RowW-1:0] below_i,
  input  logic [lgrs_pkg::CfgW-1:0] width_i,   // effective width, 1..MaxWidth
  output logic [lgrs_pkg::RowW-1:0] next_o
);
  import lgrs_pkg::*;

  logic [RowW-1:0] mask;
  logic [RowW-1:0] a_m;
  logic [RowW-1:0] c_m;
  logic [RowW-1:0] b_m;
  logic [ColW-1:0] top_idx;
  logic [2:0]      col_top;
  logic [2:0]      col_zero;

  assign top_idx  = ColW'(width_i - CfgW'(1));
  assign a_m      = above_i & mask;
  assign c_m      = centre_i & mask;
  assign b_m      = below_i & mask;
  assign col_top  = {a_m[top_idx], c_m[top_idx], b_m[top_idx]};
  assign col_zero = {a_m[0], c_m[0], b_m[0]};

  for (genvar x = 0; x < RowW; x++) begin : g_col
    assign mask[x] = (CfgW'(x) < width_i);

    if (x < MaxWidth) begin : g_lane
      nbhd_t nb;
      logic  lane_next;

      if (x == 0) begin : g_west_wrap
        assign nb.west = col_top;
      end else begin : g_west
        assign nb.west = {a_m[x-1], c_m[x-1], b_m[x-1]};
      end

      assign nb.mid = {a_m[x], c_m[x], b_m[x]};

      if (x == MaxWidth - 1) begin : g_east_wrap
        assign nb.east = col_zero;
      end else begin : g_east
        assign nb.east = (width_i == CfgW'(x + 1)) ? col_zero
                                                    : {a_m[x+1], c_m[x+1], b_m[x+1]};
      end

      lgrs_lane u_lane (
        .nbhd_i (nb),
        .next_o (lane_next)
      );

      // merge: columns beyond the width come out clear
      assign next_o[x] = lane_next & mask[x];
    end else begin : g_unused
      assign next_o[x] = 1'b0;
    end
  end

endmodule

`default_nettype wire

### rtl/life_generation_row_stream_core.sv
// An accepted transaction is held in the job register; each of its results is then registered in the output register.
// Throughput: one row per cycle while the output does not stall; the last row of a field stalls the input
// until its up to three results have shared the single row evaluator (MAX_WIDTH lanes) one per cycle.
// Reset: control state and the row counter clear, row_width returns to 64; stored
// rows are not cleared, as each is written before it is read.
// Top level of the Life generation row stream; depends on lgrs_pkg and lgrs_row_eval.
`timescale 1ns / 1ps
`default_nettype none

module life_generation_row_stream_core #(
  parameter int unsigned MAX_WIDTH = lgrs_pkg::DefMaxWidth,
  parameter int unsigned MAX_ROWS  = lgrs_pkg::DefMaxRows
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  lgrs_pkg::in_item_t        in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output lgrs_pkg::out_item_t       out_data_o,
  input  logic                      cfg_we_i,
  input  logic [lgrs_pkg::CfgW-1:0] cfg_wdata_i
);
  import lgrs_pkg::*;

  localparam logic [IdxW-1:0] RowLimit = IdxW'(MAX_ROWS - 1);

  logic [CfgW-1:0] row_width_q;
  logic [CfgW-1:0] eff_width;
  logic [RowW-1:0] width_mask;

  logic            job_valid_q;
  logic [RowW-1:0] job_row_q;
  logic            job_last_q;
  logic [1:0]      phase_q;

  logic [RowW-1:0] first_row_q;
  logic [RowW-1:0] second_row_q;
  logic [RowW-1:0] older_row_q;
  logic [RowW-1:0] newer_row_q;
  logic [IdxW-1:0] rows_seen_q;

  logic            out_valid_q;
  out_item_t       out_data_q;

  logic [1:0]      num_results;
  logic [RowW-1:0] sel_above;
  logic [RowW-1:0] sel_centre;
  logic [RowW-1:0] sel_below;
  logic [IdxW-1:0] sel_index;
  logic            sel_final;
  logic [RowW-1:0] eval_row;
  logic            issue;
  logic            job_done;
  logic            accept;
  logic            final_phase;

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= RowWidthReset;
    end else if (cfg_we_i) begin
      row_width_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    eff_width = row_width_q;
    if (row_width_q == '0) begin
      eff_width = CfgW'(1);
    end else if (row_width_q > CfgW'(MAX_WIDTH)) begin
      eff_width = CfgW'(MAX_WIDTH);
    end
  end

  always_comb begin
    for (int i = 0; i < RowW; i++) begin
      width_mask[i] = (CfgW'(i) < eff_width);
    end
  end

  // ---------------- result sequencing ----------------
  always_comb begin
    if (rows_seen_q == '0) begin
      num_results = job_last_q ? NumOne : NumNone;
    end else if (rows_seen_q == IdxW'(1)) begin
      num_results = job_last_q ? NumTwo : NumNone;
    end else begin
      num_results = job_last_q ? NumThree : NumOne;
    end
  end

  always_comb begin
    sel_above  = job_row_q;
    sel_centre = job_row_q;
    sel_below  = job_row_q;
    sel_index  = '0;
    if (rows_seen_q == IdxW'(1)) begin
      if (phase_q == 2'd0) begin
        sel_above = first_row_q;
        sel_below = first_row_q;
        sel_index = IdxW'(1);
      end else begin
        sel_centre = first_row_q;
      end
    end else if (rows_seen_q != '0) begin
      case (phase_q)
        2'd0: begin
          sel_above  = older_row_q;
          sel_centre = newer_row_q;
          sel_index  = rows_seen_q - IdxW'(1);
        end
        2'd1: begin
          sel_above = newer_row_q;
          sel_below = first_row_q;
          sel_index = rows_seen_q;
        end
        default: begin
          sel_centre = first_row_q;
          sel_below  = second_row_q;
        end
      endcase
    end
  end

  assign final_phase = (phase_q == num_results - 2'd1);
  assign sel_final   = job_last_q && final_phase;

  lgrs_row_eval #(
    .MaxWidth (MAX_WIDTH)
  ) u_row_eval (
    .above_i  (sel_above),
    .centre_i (sel_centre),
    .below_i  (sel_below),
    .width_i  (eff_width),
    .next_o   (eval_row)
  );

  assign issue    = job_valid_q && (num_results != NumNone) && (!out_valid_q || !out_stall_i);
  assign job_done = job_valid_q && ((num_results == NumNone) || (issue && final_phase));
  assign in_stall_o = job_valid_q && !job_done;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      phase_q     <= 2'd0;
    end else if (accept) begin
      job_valid_q <= 1'b1;
      phase_q     <= 2'd0;
    end else if (job_done) begin
      job_valid_q <= 1'b0;
      phase_q     <= 2'd0;
    end else if (issue) begin
      phase_q <= phase_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_row_q  <= in_data_i.row_cells & width_mask;
      job_last_q <= in_data_i.is_last_row;
    end
  end

  // ---------------- row history ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_seen_q <= '0;
    end else if (job_done) begin
      if (job_last_q) begin
        rows_seen_q <= '0;
      end else if (rows_seen_q < RowLimit) begin
        rows_seen_q <= rows_seen_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_done) begin
      newer_row_q <= job_row_q;
      if (rows_seen_q == '0) begin
        first_row_q <= job_row_q;
      end else begin
        older_row_q <= newer_row_q;
        if (rows_seen_q == IdxW'(1)) begin
          second_row_q <= job_row_q;
        end
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (issue) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      out_data_q.row_index          <= sel_index;
      out_data_q.next_row_cells     <= eval_row;
      out_data_q.last_of_generation <= sel_final;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_idle_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !job_valid_q |-> !in_stall_o)
    else $error("input stalled with no transaction in hand");

  a_last_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_done && job_last_q) |=> (rows_seen_q == '0))
    else $error("row counter not cleared at end of generation");

  a_closing_row_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.last_of_generation) |-> (out_data_o.row_index == '0))
    else $error("generation closed on a row other than row 0");

  a_width_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.next_row_cells & ~width_mask) == '0))
    else $error("live cells beyond the row width");

  a_phase_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> (phase_q < num_results))
    else $error("result phase beyond the transaction's result count");
`endif

endmodule

`default_nettype wire
